/* sv/slotalloc_pkg.sv */
// Shared types and constants for the slot allocator with reuse delay.
// Used by slotalloc_cfg, slotalloc_ctrl, slotalloc_dp and the top level.
package slotalloc_pkg;

  localparam int SLOTS_DEF     = 1024;
  localparam int TIME_BITS_DEF = 32;

  localparam int SLOT_W = 10;
  localparam int STAT_W = 2;

  // request kinds
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_ALLOC   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FREED   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_REFUSED = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd3;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_RESERVED = 3'd0;
  localparam logic [2:0] REG_BODYQ    = 3'd1;
  localparam logic [2:0] REG_LIMIT    = 3'd2;
  localparam logic [2:0] REG_DELAY    = 3'd3;
  localparam logic [2:0] REG_WINDOW   = 3'd4;

  localparam logic [9:0]  RESERVED_RST = 10'd8;
  localparam logic [6:0]  BODYQ_RST    = 7'd8;
  localparam logic [10:0] LIMIT_RST    = 11'd1024;
  localparam logic [15:0] DELAY_RST    = 16'd500;
  localparam logic [15:0] WINDOW_RST   = 16'd2000;

  typedef struct packed {
    logic [9:0]  reserved_slots;
    logic [6:0]  body_queue_slots;
    logic [10:0] slot_limit;
    logic [15:0] reuse_delay;
    logic [15:0] startup_window;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FREE,
    ST_SCAN,
    ST_APPEND,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic clear_en;
    logic take_req;
    logic scan_start;
    logic free_en;
    logic scan_en;
    logic append_en;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic hit;
    logic scan_done;
    logic out_free;
  } dp_sts_t;

endpackage

/* sv/slotalloc_cfg.sv */
// APB-style configuration registers of the slot allocator.
// Depends on slotalloc_pkg.
module slotalloc_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [4:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output slotalloc_pkg::cfg_t       cfg
);

  slotalloc_pkg::cfg_t cfg_r;
  logic                wr_en;
  logic [2:0]          reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reserved_slots   <= slotalloc_pkg::RESERVED_RST;
      cfg_r.body_queue_slots <= slotalloc_pkg::BODYQ_RST;
      cfg_r.slot_limit       <= slotalloc_pkg::LIMIT_RST;
      cfg_r.reuse_delay      <= slotalloc_pkg::DELAY_RST;
      cfg_r.startup_window   <= slotalloc_pkg::WINDOW_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        slotalloc_pkg::REG_RESERVED: cfg_r.reserved_slots   <= pwdata[9:0];
        slotalloc_pkg::REG_BODYQ:    cfg_r.body_queue_slots <= pwdata[6:0];
        slotalloc_pkg::REG_LIMIT:    cfg_r.slot_limit       <= pwdata[10:0];
        slotalloc_pkg::REG_DELAY:    cfg_r.reuse_delay      <= pwdata[15:0];
        slotalloc_pkg::REG_WINDOW:   cfg_r.startup_window   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      slotalloc_pkg::REG_RESERVED: prdata = {22'd0, cfg_r.reserved_slots};
      slotalloc_pkg::REG_BODYQ:    prdata = {25'd0, cfg_r.body_queue_slots};
      slotalloc_pkg::REG_LIMIT:    prdata = {21'd0, cfg_r.slot_limit};
      slotalloc_pkg::REG_DELAY:    prdata = {16'd0, cfg_r.reuse_delay};
      slotalloc_pkg::REG_WINDOW:   prdata = {16'd0, cfg_r.startup_window};
      default:                     prdata = 32'd0;
    endcase
  end

endmodule

/* sv/slotalloc_ctrl.sv */
// Sequencer of the slot allocator: clearing pass, request decode, free, scan, append, response.
// Depends on slotalloc_pkg; drives the command struct of slotalloc_dp.
module slotalloc_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_command,
  output logic                   in_stall,
  input  slotalloc_pkg::dp_sts_t sts,
  output slotalloc_pkg::dp_cmd_t cmd
);

  slotalloc_pkg::state_t state_r, state_nxt;
  logic                  accept;

  assign accept = in_valid & (state_r == slotalloc_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slotalloc_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      slotalloc_pkg::ST_CLEAR: begin
        if (sts.clear_last) state_nxt = slotalloc_pkg::ST_IDLE;
      end
      slotalloc_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_command == slotalloc_pkg::CMD_FREE) ? slotalloc_pkg::ST_FREE
                                                               : slotalloc_pkg::ST_SCAN;
        end
      end
      slotalloc_pkg::ST_FREE: state_nxt = slotalloc_pkg::ST_RESP;
      slotalloc_pkg::ST_SCAN: begin
        priority if (sts.hit)       state_nxt = slotalloc_pkg::ST_RESP;
        else if (sts.scan_done)     state_nxt = slotalloc_pkg::ST_APPEND;
        else                        state_nxt = slotalloc_pkg::ST_SCAN;
      end
      slotalloc_pkg::ST_APPEND: state_nxt = slotalloc_pkg::ST_RESP;
      slotalloc_pkg::ST_RESP: begin
        if (sts.out_free) state_nxt = slotalloc_pkg::ST_IDLE;
      end
      default: state_nxt = slotalloc_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state_r != slotalloc_pkg::ST_IDLE);
    unique case (state_r)
      slotalloc_pkg::ST_CLEAR:  cmd.clear_en  = 1'b1;
      slotalloc_pkg::ST_IDLE: begin
        cmd.take_req   = accept;
        cmd.scan_start = accept;
      end
      slotalloc_pkg::ST_FREE:   cmd.free_en   = 1'b1;
      slotalloc_pkg::ST_SCAN:   cmd.scan_en   = 1'b1;
      slotalloc_pkg::ST_APPEND: cmd.append_en = 1'b1;
      slotalloc_pkg::ST_RESP:   cmd.load_out  = sts.out_free;
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  // one request at a time: the beat after an accepted one is always stalled
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in a row");
`endif

endmodule

/* sv/slotalloc_dp.sv */
// Datapath of the slot allocator: slot memories, scan pointer, high-water count,
// reuse check and output register. Depends on slotalloc_pkg; steered by slotalloc_ctrl.
module slotalloc_dp #(
  parameter int SLOTS     = slotalloc_pkg::SLOTS_DEF,
  parameter int TIME_BITS = slotalloc_pkg::TIME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  slotalloc_pkg::cfg_t                 cfg,
  input  slotalloc_pkg::dp_cmd_t              cmd,
  output slotalloc_pkg::dp_sts_t              sts,
  input  logic [slotalloc_pkg::SLOT_W-1:0]    in_slot_index,
  input  logic [31:0]                         in_time_now,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [slotalloc_pkg::SLOT_W-1:0]    out_granted_slot,
  output logic [slotalloc_pkg::STAT_W-1:0]    out_status
);

  localparam int PW = $clog2(SLOTS);
  localparam int CW = PW + 1;
  localparam int EW = (CW > 11) ? CW : 11;
  localparam int TW = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam int SW = (TIME_BITS > 16) ? TIME_BITS : 16;
  localparam logic [EW-1:0] SLOTS_E = EW'(SLOTS);
  localparam logic [EW-1:0] LAST_E  = EW'(SLOTS - 1);

  localparam int SLW = slotalloc_pkg::SLOT_W;
  localparam int STW = slotalloc_pkg::STAT_W;

  logic                 busy_mem  [SLOTS];
  logic [TIME_BITS-1:0] stamp_mem [SLOTS];

  logic [SLW-1:0]       idx_r;
  logic [TIME_BITS-1:0] now_r;
  logic [EW-1:0]        ptr_r;
  logic [CW-1:0]        hw_r;
  logic                 chk_valid_r;
  logic [EW-1:0]        chk_ptr_r;
  logic                 busy_rd_r;
  logic [TIME_BITS-1:0] stamp_rd_r;
  logic [SLW-1:0]       res_slot_r;
  logic [STW-1:0]       res_status_r;
  logic                 out_valid_r;
  logic [SLW-1:0]       out_slot_r;
  logic [STW-1:0]       out_status_r;

  logic [TW-1:0]        now_wide;
  logic [TIME_BITS-1:0] now_in;
  logic [EW-1:0]        start;
  logic [EW-1:0]        hw_e;
  logic                 issue_ok;
  logic [TIME_BITS-1:0] age;
  logic                 early;
  logic                 aged;
  logic                 hit;
  logic [EW-1:0]        idx_e;
  logic [EW-1:0]        prot_top;
  logic                 free_ok;
  logic [EW-1:0]        app_slot;
  logic [EW-1:0]        cap;
  logic                 full;
  logic [EW-1:0]        app_next;

  logic                 busy_we;
  logic                 stamp_we;
  logic [PW-1:0]        wr_addr;
  logic                 wr_busy;
  logic [TIME_BITS-1:0] wr_stamp;

  assign now_wide = TW'(in_time_now);
  assign now_in   = now_wide[TIME_BITS-1:0];

  assign start    = EW'(cfg.reserved_slots) + EW'(1);
  assign hw_e     = EW'(hw_r);
  assign issue_ok = ptr_r < hw_e;

  // reuse check on the slot read last cycle
  assign age   = now_r - stamp_rd_r;
  assign early = SW'(stamp_rd_r) < SW'(cfg.startup_window);
  assign aged  = SW'(age) > SW'(cfg.reuse_delay);
  assign hit   = cmd.scan_en & chk_valid_r & ~busy_rd_r & (early | aged);

  assign idx_e    = EW'(idx_r);
  assign prot_top = EW'(cfg.reserved_slots) + EW'(cfg.body_queue_slots);
  assign free_ok  = (idx_e > prot_top) && (idx_e < SLOTS_E);

  assign app_slot = (hw_e > start) ? hw_e : start;
  assign cap      = (EW'(cfg.slot_limit) < SLOTS_E) ? EW'(cfg.slot_limit) : SLOTS_E;
  assign full     = app_slot >= cap;
  assign app_next = app_slot + EW'(1);

  assign sts.clear_last = (ptr_r == LAST_E);
  assign sts.hit        = hit;
  assign sts.scan_done  = ~issue_ok & ~chk_valid_r;
  assign sts.out_free   = ~out_valid_r | ~out_stall;

  always_comb begin
    busy_we  = 1'b0;
    stamp_we = 1'b0;
    wr_addr  = ptr_r[PW-1:0];
    wr_busy  = 1'b0;
    wr_stamp = '0;
    priority if (cmd.clear_en) begin
      busy_we  = 1'b1;
      stamp_we = 1'b1;
    end else if (cmd.free_en && free_ok) begin
      busy_we  = 1'b1;
      stamp_we = 1'b1;
      wr_addr  = idx_e[PW-1:0];
      wr_stamp = now_r;
    end else if (hit) begin
      busy_we  = 1'b1;
      wr_addr  = chk_ptr_r[PW-1:0];
      wr_busy  = 1'b1;
    end else if (cmd.append_en && !full) begin
      busy_we  = 1'b1;
      wr_addr  = app_slot[PW-1:0];
      wr_busy  = 1'b1;
    end else begin
      busy_we  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_we) busy_mem[wr_addr] <= wr_busy;
    if (stamp_we) stamp_mem[wr_addr] <= wr_stamp;
    if (cmd.scan_en && issue_ok) begin
      busy_rd_r  <= busy_mem[ptr_r[PW-1:0]];
      stamp_rd_r <= stamp_mem[ptr_r[PW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      hw_r        <= '0;
      chk_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear_en) begin
        ptr_r <= ptr_r + EW'(1);
      end else if (cmd.scan_start) begin
        ptr_r <= start;
      end else if (cmd.scan_en && issue_ok) begin
        ptr_r <= ptr_r + EW'(1);
      end
      chk_valid_r <= cmd.scan_en & issue_ok & ~hit;
      if (cmd.append_en && !full) hw_r <= app_next[CW-1:0];
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_ptr_r <= ptr_r;
    if (cmd.take_req) begin
      idx_r <= in_slot_index;
      now_r <= now_in;
    end
    priority if (cmd.free_en) begin
      res_slot_r   <= idx_r;
      res_status_r <= free_ok ? slotalloc_pkg::STAT_FREED : slotalloc_pkg::STAT_REFUSED;
    end else if (hit) begin
      res_slot_r   <= chk_ptr_r[SLW-1:0];
      res_status_r <= slotalloc_pkg::STAT_ALLOC;
    end else if (cmd.append_en) begin
      res_slot_r   <= full ? '0 : app_slot[SLW-1:0];
      res_status_r <= full ? slotalloc_pkg::STAT_FULL : slotalloc_pkg::STAT_ALLOC;
    end else begin
      res_slot_r   <= res_slot_r;
    end
    if (cmd.load_out) begin
      out_slot_r   <= res_slot_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_granted_slot = out_slot_r;
  assign out_status       = out_status_r;

`ifndef ASSERT_OFF
  a_hw_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    hw_r <= CW'(SLOTS))
    else $error("high-water count beyond table");

  a_grant_below_hw: assert property (@(posedge clk) disable iff (!rst_n)
    hit |-> (chk_ptr_r < hw_e) && (chk_ptr_r >= start))
    else $error("reused slot outside scanned range");

  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.load_out))
    else $error("result shown without a load");
`endif

endmodule

/* sv/slot_allocator_with_reuse_delay.sv */
// Slot allocator with reuse delay: a free passes through the FREE and RESP states and its
// result is then loaded into the output register. An allocate scans one slot per cycle from
// the slot memory, from just above the reserved slots up to the high-water count, and takes
// the first reusable one; else it appends at the high-water count or reports full. One request
// at a time: the next is taken the cycle after the result is loaded, later while the output
// beat is stalled. Reset is synchronous, active low; a clearing pass then zeroes every slot.
module slot_allocator_with_reuse_delay #(
  parameter int SLOTS     = slotalloc_pkg::SLOTS_DEF,
  parameter int TIME_BITS = slotalloc_pkg::TIME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_command,
  input  logic [slotalloc_pkg::SLOT_W-1:0] in_slot_index,
  input  logic [31:0]                      in_time_now,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [slotalloc_pkg::SLOT_W-1:0] out_granted_slot,
  output logic [slotalloc_pkg::STAT_W-1:0] out_status,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [4:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  slotalloc_pkg::cfg_t    cfg;
  slotalloc_pkg::dp_cmd_t cmd;
  slotalloc_pkg::dp_sts_t sts;

  slotalloc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  slotalloc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  slotalloc_dp #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .sts              (sts),
    .in_slot_index    (in_slot_index),
    .in_time_now      (in_time_now),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_granted_slot (out_granted_slot),
    .out_status       (out_status)
  );

endmodule

/* sim/tb_slot_allocator_with_reuse_delay.sv */
// Self-checking testbench for slot_allocator_with_reuse_delay: directed, back-pressure,
// randomized register phases and top-of-table tests against an in-bench allocator model.
// Depends on slotalloc_pkg and the slot_allocator_with_reuse_delay RTL only.
module tb_slot_allocator_with_reuse_delay;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TB_SLOTS     = slotalloc_pkg::SLOTS_DEF;
  localparam int CYCLE_LIMIT  = 4000000;
  localparam int HOLD_CYCLES  = 1500;
  localparam int RANDOM_ITEMS = 500;
  localparam logic [2:0] REG_UNUSED = slotalloc_pkg::REG_WINDOW + 3'd1;

  typedef struct packed {
    logic [slotalloc_pkg::SLOT_W-1:0] slot;
    logic [slotalloc_pkg::STAT_W-1:0] status;
  } grant_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic                             in_command = slotalloc_pkg::CMD_ALLOC;
  logic [slotalloc_pkg::SLOT_W-1:0] in_slot_index = '0;
  logic [31:0]                      in_time_now = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [slotalloc_pkg::SLOT_W-1:0] out_granted_slot;
  logic [slotalloc_pkg::STAT_W-1:0] out_status;
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [4:0]                       paddr = '0;
  logic [31:0]                      pwdata = '0;
  logic [31:0]                      prdata;
  logic                             pready;

  slot_allocator_with_reuse_delay dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_slot_index    (in_slot_index),
    .in_time_now      (in_time_now),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_granted_slot (out_granted_slot),
    .out_status       (out_status),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #5 clk = ~clk;

  // allocator model state
  slotalloc_pkg::cfg_t m_cfg;
  bit                  m_busy [TB_SLOTS];
  logic [31:0]         m_stamp [TB_SLOTS];
  int unsigned         m_hw;

  grant_t      grant_queue [$];
  int          fail_count = 0;
  int          cycle_count = 0;
  logic [31:0] tick = '0;

  logic        idle_on = 1'b1;
  int          hold_token = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  function automatic bit slot_reusable(int s, logic [31:0] now);
    logic [31:0] age;
    if (m_busy[s]) return 1'b0;
    if (m_stamp[s] < 32'(m_cfg.startup_window)) return 1'b1;
    age = now - m_stamp[s];
    return age > 32'(m_cfg.reuse_delay);
  endfunction

  function automatic grant_t predict_grant(logic cmd, logic [slotalloc_pkg::SLOT_W-1:0] idx,
                                           logic [31:0] now);
    grant_t r;
    int     first, stop, cap, s;
    if (cmd == slotalloc_pkg::CMD_FREE) begin
      r.slot = idx;
      if (int'(idx) <= int'(m_cfg.reserved_slots) + int'(m_cfg.body_queue_slots) ||
          int'(idx) >= TB_SLOTS) begin
        r.status = slotalloc_pkg::STAT_REFUSED;
      end else begin
        m_stamp[idx] = now;
        m_busy[idx]  = 1'b0;
        r.status     = slotalloc_pkg::STAT_FREED;
      end
      return r;
    end
    first = int'(m_cfg.reserved_slots) + 1;
    stop  = (int'(m_hw) < TB_SLOTS) ? int'(m_hw) : TB_SLOTS;
    cap   = (int'(m_cfg.slot_limit) < TB_SLOTS) ? int'(m_cfg.slot_limit) : TB_SLOTS;
    for (s = first; s < stop; s++) begin
      if (slot_reusable(s, now)) begin
        // reuse keeps the old stamp
        m_busy[s] = 1'b1;
        r.slot    = slotalloc_pkg::SLOT_W'(s);
        r.status  = slotalloc_pkg::STAT_ALLOC;
        return r;
      end
    end
    s = (int'(m_hw) > first) ? int'(m_hw) : first;
    if (s >= cap) begin
      r.slot   = '0;
      r.status = slotalloc_pkg::STAT_FULL;
      return r;
    end
    m_busy[s] = 1'b1;
    m_hw      = s + 1;
    r.slot    = slotalloc_pkg::SLOT_W'(s);
    r.status  = slotalloc_pkg::STAT_ALLOC;
    return r;
  endfunction

  function automatic logic [31:0] reg_value(logic [2:0] idx);
    unique case (idx)
      slotalloc_pkg::REG_RESERVED: return 32'(m_cfg.reserved_slots);
      slotalloc_pkg::REG_BODYQ:    return 32'(m_cfg.body_queue_slots);
      slotalloc_pkg::REG_LIMIT:    return 32'(m_cfg.slot_limit);
      slotalloc_pkg::REG_DELAY:    return 32'(m_cfg.reuse_delay);
      slotalloc_pkg::REG_WINDOW:   return 32'(m_cfg.startup_window);
      default:                     return '0;
    endcase
  endfunction

  function automatic logic [slotalloc_pkg::SLOT_W-1:0] pick_busy_slot();
    int lo, hi, s;
    lo = int'(m_cfg.reserved_slots) + 1;
    hi = int'(m_hw);
    if (hi > lo) begin
      for (int k = 0; k < 8; k++) begin
        s = $urandom_range(lo, hi - 1);
        if (m_busy[s]) return slotalloc_pkg::SLOT_W'(s);
      end
    end
    return slotalloc_pkg::SLOT_W'($urandom_range(0, TB_SLOTS - 1));
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, grant_queue.size());
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stall, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_on && ($urandom_range(0, 99) < 23);
    end
  end

  // result check first, then predict the beat accepted at this edge
  always @(posedge clk) begin
    grant_t want;
    grant_t got;
    grant_t pred;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.slot   = out_granted_slot;
        got.status = out_status;
        if (grant_queue.size() == 0) begin
          fail_count++;
          $display("%0t ERROR unexpected result: expected none, actual slot %0d status %0d",
                   $time, got.slot, got.status);
        end else begin
          want = grant_queue.pop_front();
          if (got.slot !== want.slot) begin
            fail_count++;
            $display("%0t ERROR granted_slot: expected %0d, actual %0d",
                     $time, want.slot, got.slot);
          end
          if (got.status !== want.status) begin
            fail_count++;
            $display("%0t ERROR status: expected %0d, actual %0d",
                     $time, want.status, got.status);
          end
        end
      end
      if (in_valid && !in_stall) begin
        pred        = predict_grant(in_command, in_slot_index, in_time_now);
        grant_queue = {grant_queue, pred};
      end
    end
  end

  task automatic send_req(logic cmd, logic [slotalloc_pkg::SLOT_W-1:0] idx, logic [31:0] now);
    int gap;
    gap = 0;
    if (idle_on) begin
      while (gap < 40 && $urandom_range(0, 99) < 23) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_slot_index <= idx;
    in_time_now   <= now;
    do @(posedge clk); while (in_stall);
  endtask

  // one edge first so the beat accepted at the last edge is already queued
  task automatic wait_results_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (grant_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    unique case (idx)
      slotalloc_pkg::REG_RESERVED: m_cfg.reserved_slots   = data[9:0];
      slotalloc_pkg::REG_BODYQ:    m_cfg.body_queue_slots = data[6:0];
      slotalloc_pkg::REG_LIMIT:    m_cfg.slot_limit       = data[10:0];
      slotalloc_pkg::REG_DELAY:    m_cfg.reuse_delay      = data[15:0];
      slotalloc_pkg::REG_WINDOW:   m_cfg.startup_window   = data[15:0];
      default: ;
    endcase
    // back-to-back read of the same address
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx <= slotalloc_pkg::REG_WINDOW) begin
      want = reg_value(idx);
      if (prdata !== want) begin
        fail_count++;
        $display("%0t ERROR prdata at reg %0d: expected %0d, actual %0d",
                 $time, idx, want, prdata);
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // junk above each register's width must be dropped
  task automatic apply_config(int res, int bq, int lim, int dly, int win);
    write_reg(slotalloc_pkg::REG_RESERVED, ($urandom << 10) | 32'(res));
    write_reg(slotalloc_pkg::REG_BODYQ,    ($urandom << 7)  | 32'(bq));
    write_reg(slotalloc_pkg::REG_LIMIT,    ($urandom << 11) | 32'(lim));
    write_reg(slotalloc_pkg::REG_DELAY,    ($urandom << 16) | 32'(dly));
    write_reg(slotalloc_pkg::REG_WINDOW,   ($urandom << 16) | 32'(win));
    if ($urandom_range(0, 2) == 0)
      write_reg(REG_UNUSED + 3'($urandom_range(0, 2)), $urandom);
  endtask

  task automatic advance_tick();
    if ($urandom_range(0, 99) < 3) tick = tick + $urandom;
    else tick = tick + $urandom_range(0, (int'(m_cfg.reuse_delay) >> 2) + 4);
  endtask

  task automatic reset_dut();
    m_cfg.reserved_slots   = slotalloc_pkg::RESERVED_RST;
    m_cfg.body_queue_slots = slotalloc_pkg::BODYQ_RST;
    m_cfg.slot_limit       = slotalloc_pkg::LIMIT_RST;
    m_cfg.reuse_delay      = slotalloc_pkg::DELAY_RST;
    m_cfg.startup_window   = slotalloc_pkg::WINDOW_RST;
    for (int s = 0; s < TB_SLOTS; s++) begin
      m_busy[s]  = 1'b0;
      m_stamp[s] = '0;
    end
    m_hw = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  task automatic test_directed();
    apply_config(2, 3, 12, 100, 50);
    send_req(slotalloc_pkg::CMD_ALLOC, '1, 32'd0);          // opens slot after reserved
    repeat (4) send_req(slotalloc_pkg::CMD_ALLOC, '0, 32'd1);
    send_req(slotalloc_pkg::CMD_FREE, 10'd5, 32'd10);       // protected body-queue slot
    send_req(slotalloc_pkg::CMD_FREE, 10'd6, 32'd10);       // stamp inside startup window
    send_req(slotalloc_pkg::CMD_ALLOC, '0, 32'd11);         // reused at once
    send_req(slotalloc_pkg::CMD_FREE, 10'd7, 32'd60);
    send_req(slotalloc_pkg::CMD_ALLOC, '0, 32'd100);        // too young, append
    send_req(slotalloc_pkg::CMD_ALLOC, '0, 32'd160);        // age equals delay, append
    send_req(slotalloc_pkg::CMD_ALLOC, '0, 32'd161);        // age just over delay, reuse
    send_req(slotalloc_pkg::CMD_ALLOC, '0, 32'd162);
    send_req(slotalloc_pkg::CMD_ALLOC, '0, 32'd163);
    send_req(slotalloc_pkg::CMD_ALLOC, '0, 32'd164);        // table full at limit
    send_req(slotalloc_pkg::CMD_FREE, '1, 32'd200);         // never opened slot
    send_req(slotalloc_pkg::CMD_FREE, '0, 32'd200);
    send_req(slotalloc_pkg::CMD_ALLOC, '0, 32'd200);
    send_req(slotalloc_pkg::CMD_FREE, 10'd8, 32'hFFFF_FFF0);
    send_req(slotalloc_pkg::CMD_ALLOC, '0, 32'h0000_0010);  // age across the wrap, still young
    send_req(slotalloc_pkg::CMD_ALLOC, '0, 32'h0000_0080);  // wrapped age over delay
    tick = 32'h0000_0080;
    wait_results_done();
  endtask

  task automatic test_backpressure();
    int roll;
    apply_config(4, 2, 40, 20, 0);
    idle_on    <= 1'b1;
    hold_token <= hold_token + 1;
    repeat (14) begin
      advance_tick();
      roll = $urandom_range(0, 1);
      if (roll == 0) send_req(slotalloc_pkg::CMD_ALLOC, slotalloc_pkg::SLOT_W'($urandom), tick);
      else send_req(slotalloc_pkg::CMD_FREE, pick_busy_slot(), tick);
    end
    wait_results_done();
  endtask

  task automatic test_random_phases();
    int done_items, phase, n, roll;
    int res, bq, lim, dly, win, base;
    done_items = 0;
    phase = 0;
    while (done_items < RANDOM_ITEMS) begin
      res  = $urandom_range(0, 12);
      bq   = $urandom_range(0, 6);
      base = (int'(m_hw) > res + 1) ? int'(m_hw) : res + 1;
      if ($urandom_range(0, 3) == 0) lim = $urandom_range(1, base);
      else lim = base + $urandom_range(0, 20);
      if (lim > TB_SLOTS) lim = TB_SLOTS;
      dly = $urandom_range(0, 300);
      win = $urandom_range(0, 3000);
      unique case (phase)
        0: begin
          res = 0; bq = 0; lim = 1; dly = 0; win = 0;
        end
        1: begin
          bq = 64; lim = TB_SLOTS; dly = 65535; win = 65535;
        end
        default: ;
      endcase
      idle_on <= (phase != 3);   // one long stretch without idling
      apply_config(res, bq, lim, dly, win);
      n = $urandom_range(30, 60);
      repeat (n) begin
        advance_tick();
        roll = $urandom_range(0, 99);
        if (roll < 50)
          send_req(slotalloc_pkg::CMD_ALLOC, slotalloc_pkg::SLOT_W'($urandom), tick);
        else if (roll < 88)
          send_req(slotalloc_pkg::CMD_FREE, pick_busy_slot(), tick);
        else
          send_req(slotalloc_pkg::CMD_FREE, slotalloc_pkg::SLOT_W'($urandom), tick);
        done_items++;
      end
      wait_results_done();
      phase++;
    end
    idle_on <= 1'b1;
  endtask

  // reserved at its top: one slot left below the table end
  task automatic test_top_of_table();
    apply_config(1022, 0, TB_SLOTS, 0, 0);
    tick = tick + 32'd10;
    send_req(slotalloc_pkg::CMD_ALLOC, '0, tick);
    send_req(slotalloc_pkg::CMD_ALLOC, '0, tick);
    send_req(slotalloc_pkg::CMD_FREE, 10'd1023, tick);
    send_req(slotalloc_pkg::CMD_ALLOC, '0, tick);
    send_req(slotalloc_pkg::CMD_ALLOC, '0, tick + 32'd1);
    send_req(slotalloc_pkg::CMD_FREE, 10'd1022, tick + 32'd2);
    wait_results_done();
    apply_config(1022, 64, TB_SLOTS, 0, 0);
    send_req(slotalloc_pkg::CMD_FREE, 10'd1023, tick + 32'd3);
    send_req(slotalloc_pkg::CMD_ALLOC, '0, tick + 32'd4);
    wait_results_done();
  endtask

  initial begin
    reset_dut();
    test_directed();
    test_backpressure();
    test_random_phases();
    test_top_of_table();
    repeat (40) @(posedge clk);
    if (grant_queue.size() != 0) begin
      fail_count++;
      $display("%0t ERROR results missing: expected 0 outstanding, actual %0d",
               $time, grant_queue.size());
    end
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
